[hw/rtl/eqpx_pkg.sv]
package eqpx_pkg;

  localparam int unsigned SAMPLE_BITS     = 24;
  localparam int unsigned TABLE_ADDR_BITS = 10;
  localparam int unsigned GAIN_FRAC_BITS  = 16;

  localparam int unsigned POS_BITS = 16;
  localparam int signed   POS_FULL = 16384;

  localparam longint unsigned Q30_ONE     = 64'd1 << 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Shift-subtract quotient, elaboration only.
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = 64'd0;
    r = 64'd0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= den) begin
        r    = r - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Quarter-wave sine entry k, Q1.frac_bits with unity capped.
  // Q30 Horner series, evaluated at elaboration only.
  function automatic logic [31:0] sine_entry(input int unsigned k,
                                             input int unsigned addr_bits,
                                             input int unsigned frac_bits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned term;
    longint unsigned dv;
    longint unsigned s;
    longint unsigned g;
    longint unsigned cap;
    x   = (longint'(k) * HALF_PI_Q30) >> addr_bits;
    x2  = (x * x) >> 30;
    t   = Q30_ONE;
    cap = 64'd1 << frac_bits;
    for (int n = 8; n >= 1; n--) begin
      dv   = longint'(2 * n) * longint'(2 * n + 1);
      term = udiv64((x2 * t) >> 30, dv);
      t    = (term > Q30_ONE) ? 64'd0 : Q30_ONE - term;
    end
    s = (x * t) >> 30;
    g = (s + (64'd1 << (29 - frac_bits))) >> (30 - frac_bits);
    if (g > cap) begin
      g = cap;
    end
    return g[31:0];
  endfunction

endpackage

[hw/rtl/equal_power_crossfader_top.sv]
// Channel | Signals                                   | Dir | Item
// --------+-------------------------------------------+-----+---------------------------------
// in      | in_valid_i in_ready_o position_i          | in  | position, sample A, sample B
//         | sample_a_i sample_b_i                     |     |
// out     | out_valid_o out_ready_i mixed_sample_o    | out | mixed sample, saturation flag
//         | clipped_flag_o                            |     |
//
// One item per cycle unless stalled; stages: index, ROM read, multiply, sum/round/saturate.
// Each stage holds its item only while the stage after it is full and stalled, so bubbles
// are squeezed out; input stalls only when all four stages are full and the output waits.
// Async active-low reset clears the stage valid bits; no table init (ROM is constant).
module equal_power_crossfader_top #(
  parameter int unsigned SAMPLE_BITS     = eqpx_pkg::SAMPLE_BITS,
  parameter int unsigned TABLE_ADDR_BITS = eqpx_pkg::TABLE_ADDR_BITS,
  parameter int unsigned GAIN_FRAC_BITS  = eqpx_pkg::GAIN_FRAC_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [eqpx_pkg::POS_BITS-1:0] position_i,
  input  logic signed [SAMPLE_BITS-1:0]        sample_a_i,
  input  logic signed [SAMPLE_BITS-1:0]        sample_b_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]        mixed_sample_o,
  output logic                                 clipped_flag_o
);

  localparam int unsigned IW       = TABLE_ADDR_BITS + 1;
  localparam int unsigned TAB_LEN  = (1 << TABLE_ADDR_BITS) + 1;
  localparam int unsigned GW       = GAIN_FRAC_BITS + 1;
  localparam int unsigned PW       = SAMPLE_BITS + GW;
  localparam int unsigned AW       = PW + 1;
  localparam int unsigned RW       = AW - GAIN_FRAC_BITS;
  localparam int unsigned PB       = eqpx_pkg::POS_BITS;
  localparam int unsigned IDX_SH   = 15 - TABLE_ADDR_BITS;
  localparam int unsigned IDX_HALF = 1 << (14 - TABLE_ADDR_BITS);

  localparam logic signed [PB-1:0] POS_HI = PB'(eqpx_pkg::POS_FULL);
  localparam logic signed [PB-1:0] POS_LO = PB'(-eqpx_pkg::POS_FULL);
  localparam logic [IW-1:0]        IDX_MAX = IW'(1 << TABLE_ADDR_BITS);
  localparam logic signed [AW-1:0] RND = AW'(1 << (GAIN_FRAC_BITS - 1));
  localparam logic signed [RW-1:0] OUT_HI = RW'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
  localparam logic signed [RW-1:0] OUT_LO = -OUT_HI - RW'(1);

  // gain table
  logic [GW-1:0] rom_w [TAB_LEN];
  for (genvar k = 0; k < TAB_LEN; k++) begin : g_rom
    localparam logic [31:0] ENTRY =
      eqpx_pkg::sine_entry(k, TABLE_ADDR_BITS, GAIN_FRAC_BITS);
    assign rom_w[k] = ENTRY[GW-1:0];
  end

  // stage enables
  logic en1, en2, en3, en4;
  logic v1_q, v2_q, v3_q, v4_q;

  assign en4 = !v4_q || out_ready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  // stage 1: clip and index
  logic signed [PB-1:0] pos_c;
  logic [PB-1:0]        u_w;
  logic [PB-1:0]        idx_full;
  logic [IW-1:0]        idx_d;
  logic [IW-1:0]        idx_b_q, idx_a_q;
  logic signed [SAMPLE_BITS-1:0] a1_q, b1_q;

  always_comb begin
    if (position_i > POS_HI) begin
      pos_c = POS_HI;
    end else if (position_i < POS_LO) begin
      pos_c = POS_LO;
    end else begin
      pos_c = position_i;
    end
    u_w      = PB'(pos_c + POS_HI);
    idx_full = (u_w + PB'(IDX_HALF)) >> IDX_SH;
    if (idx_full > PB'(IDX_MAX)) begin
      idx_d = IDX_MAX;
    end else begin
      idx_d = idx_full[IW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      idx_b_q <= idx_d;
      idx_a_q <= IDX_MAX - idx_d;
      a1_q    <= sample_a_i;
      b1_q    <= sample_b_i;
    end
  end

  // stage 2: gain ROM read
  logic [GW-1:0] gain_a_q, gain_b_q;
  logic signed [SAMPLE_BITS-1:0] a2_q, b2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      gain_a_q <= rom_w[idx_a_q];
      gain_b_q <= rom_w[idx_b_q];
      a2_q     <= a1_q;
      b2_q     <= b1_q;
    end
  end

  // stage 3: multiply
  logic signed [PW-1:0] prod_a_q, prod_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      prod_a_q <= PW'(a2_q * $signed({1'b0, gain_a_q}));
      prod_b_q <= PW'(b2_q * $signed({1'b0, gain_b_q}));
    end
  end

  // stage 4: sum, round, saturate
  logic signed [AW-1:0] acc_w;
  logic signed [RW-1:0] r_w;
  logic signed [SAMPLE_BITS-1:0] mix_d;
  logic clip_d;
  logic signed [SAMPLE_BITS-1:0] mix_q;
  logic clip_q;

  always_comb begin
    acc_w = AW'(prod_a_q) + AW'(prod_b_q) + RND;
    r_w   = RW'(acc_w >>> GAIN_FRAC_BITS);
    if (r_w > OUT_HI) begin
      mix_d  = OUT_HI[SAMPLE_BITS-1:0];
      clip_d = 1'b1;
    end else if (r_w < OUT_LO) begin
      mix_d  = OUT_LO[SAMPLE_BITS-1:0];
      clip_d = 1'b1;
    end else begin
      mix_d  = r_w[SAMPLE_BITS-1:0];
      clip_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      mix_q  <= mix_d;
      clip_q <= clip_d;
    end
  end

  assign out_valid_o    = v4_q;
  assign mixed_sample_o = mix_q;
  assign clipped_flag_o = clip_q;

endmodule

[hw/rtl/eqpx_checker.sv]
module eqpx_checker #(
  parameter int unsigned SAMPLE_BITS = eqpx_pkg::SAMPLE_BITS
) (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_o,
  input logic signed [eqpx_pkg::POS_BITS-1:0] position_i,
  input logic signed [SAMPLE_BITS-1:0]        sample_a_i,
  input logic signed [SAMPLE_BITS-1:0]        sample_b_i,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic signed [SAMPLE_BITS-1:0]        mixed_sample_o,
  input logic                                 clipped_flag_o
);

  localparam logic [SAMPLE_BITS-1:0] MAX_S = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] MIN_S = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // while the output is ready, nothing may block the input
  a_ready_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while output drains");

  // saturation flag only with a rail value
  a_clip_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && clipped_flag_o) |->
      (mixed_sample_o == MAX_S || mixed_sample_o == MIN_S))
    else $error("clipped item not at a rail");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(mixed_sample_o) && $stable(clipped_flag_o)))
    else $error("stalled output item changed");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_ready_o) |=>
      (in_valid_i && $stable(position_i) && $stable(sample_a_i) && $stable(sample_b_i)))
    else $error("stalled input item changed");

endmodule

bind equal_power_crossfader_top eqpx_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_eqpx_checker (.*);
